[src/groestl256_hash_core_unit_defines.svh]
// Assertion macros used by the port-level checker of the hash core.
`ifndef GROESTL256_HASH_CORE_UNIT_DEFINES_SVH
`define GROESTL256_HASH_CORE_UNIT_DEFINES_SVH

// Checks an implication that must hold at every clock edge out of reset.
`define GHC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hash core assertion failed");

// Checks that one condition is followed by another in the next cycle.
`define GHC_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("hash core sequence assertion failed");

`endif

[src/ghc_pkg.sv]
// Types, constants and round function of the hash core.
package ghc_pkg;

  typedef logic [7:0][63:0] state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WRITE,
    OP_LOAD_P,
    OP_ROUND_P,
    OP_LOAD_Q,
    OP_ROUND_Q,
    OP_FOLD,
    OP_PAD,
    OP_CLEAR,
    OP_LEN,
    OP_LOAD_OUT,
    OP_RESTART
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] rnd;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic extra;
  } status_t;

  localparam logic [63:0] CV_INIT_LAST = 64'h100;
  localparam logic [6:0]  BLOCK_BYTES  = 7'd64;
  localparam logic [6:0]  PAD_LIMIT    = 7'd56;

  localparam logic [2:0] SHIFT_Q [8] = '{3'd1, 3'd3, 3'd5, 3'd7, 3'd0, 3'd2, 3'd4, 3'd6};
  localparam logic [2:0] MIX_COEF [8] = '{3'd2, 3'd2, 3'd3, 3'd4, 3'd5, 3'd3, 3'd5, 3'd7};

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] xtime(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [2:0] c, logic [7:0] x);
    logic [7:0] acc;
    logic [7:0] v;
    acc = 8'h00;
    v   = x;
    for (int k = 0; k < 3; k++) begin
      if (c[k]) begin
        acc = acc ^ v;
      end
      v = xtime(v);
    end
    return acc;
  endfunction

  function automatic state_t round_f(state_t s, logic is_q, logic [7:0] r);
    logic [7:0] m [8][8];
    logic [7:0] t [8][8];
    logic [7:0] rc;
    logic [7:0] acc;
    logic [2:0] sh;
    logic [2:0] jj;
    logic [2:0] ii;
    state_t     res;
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        m[i][j] = s[j][63 - 8 * i -: 8];
      end
    end
    for (int j = 0; j < 8; j++) begin
      rc = {4'(j), 4'h0} ^ r;
      if (!is_q) begin
        m[0][j] = m[0][j] ^ rc;
      end else begin
        for (int i = 0; i < 8; i++) begin
          m[i][j] = m[i][j] ^ 8'hff;
        end
        m[7][j] = m[7][j] ^ rc;
      end
    end
    for (int i = 0; i < 8; i++) begin
      sh = is_q ? SHIFT_Q[i] : 3'(i);
      for (int j = 0; j < 8; j++) begin
        jj = 3'(j) + sh;
        t[i][j] = SBOX[m[i][jj]];
      end
    end
    for (int j = 0; j < 8; j++) begin
      for (int i = 0; i < 8; i++) begin
        acc = 8'h00;
        for (int k = 0; k < 8; k++) begin
          ii = 3'(i) + 3'(k);
          acc = acc ^ gf_mul(MIX_COEF[k], t[ii][j]);
        end
        res[j][63 - 8 * i -: 8] = acc;
      end
    end
    return res;
  endfunction

endpackage

[src/ghc_datapath.sv]
// Datapath of the hash core: message block, chaining value, work state and round unit.
module ghc_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ghc_pkg::cmd_t   cmd_i,
  input  logic [63:0]     msg_word_i,
  input  logic [3:0]      valid_bytes_i,
  input  logic            last_item_i,
  input  logic [1:0]      word_index_i,
  output ghc_pkg::status_t status_o,
  output logic [63:0]     digest_word_o
);

  ghc_pkg::state_t cv_q, cv_d;
  ghc_pkg::state_t blk_q, blk_d;
  ghc_pkg::state_t ws_q, ws_d;
  ghc_pkg::state_t pout_q, pout_d;
  logic [6:0]      fill_q, fill_d;
  logic [63:0]     count_q, count_d;

  logic [3:0]      nbytes;
  logic [63:0]     masked;
  logic [2:0]      pad_w;
  logic [2:0]      pad_b;
  logic [2:0]      out_sel;

  always_comb begin
    nbytes = last_item_i ? ((valid_bytes_i > 4'd8) ? 4'd8 : valid_bytes_i) : 4'd8;
    for (int b = 0; b < 8; b++) begin
      masked[63 - 8 * b -: 8] = (4'(b) < nbytes) ? msg_word_i[63 - 8 * b -: 8] : 8'h00;
    end
  end

  assign pad_w = fill_q[5:3];
  assign pad_b = fill_q[2:0];

  always_comb begin
    cv_d    = cv_q;
    blk_d   = blk_q;
    ws_d    = ws_q;
    pout_d  = pout_q;
    fill_d  = fill_q;
    count_d = count_q;
    case (cmd_i.op)
      ghc_pkg::OP_WRITE: begin
        blk_d[fill_q[5:3]] = masked;
        fill_d = fill_q + 7'(nbytes);
      end
      ghc_pkg::OP_LOAD_P: begin
        ws_d = cv_q ^ blk_q;
      end
      ghc_pkg::OP_ROUND_P: begin
        ws_d = ghc_pkg::round_f(ws_q, 1'b0, cmd_i.rnd);
      end
      ghc_pkg::OP_LOAD_Q: begin
        pout_d = ws_q;
        ws_d   = blk_q;
      end
      ghc_pkg::OP_ROUND_Q: begin
        ws_d = ghc_pkg::round_f(ws_q, 1'b1, cmd_i.rnd);
      end
      ghc_pkg::OP_FOLD: begin
        cv_d    = cv_q ^ pout_q ^ ws_q;
        count_d = count_q + 64'd1;
        fill_d  = '0;
      end
      ghc_pkg::OP_PAD: begin
        for (int x = 0; x < 8; x++) begin
          for (int b = 0; b < 8; b++) begin
            if (3'(x) > pad_w || (3'(x) == pad_w && 3'(b) > pad_b)) begin
              blk_d[x][63 - 8 * b -: 8] = 8'h00;
            end else if (3'(x) == pad_w && 3'(b) == pad_b) begin
              blk_d[x][63 - 8 * b -: 8] = 8'h80;
            end
          end
        end
      end
      ghc_pkg::OP_CLEAR: begin
        blk_d = '0;
      end
      ghc_pkg::OP_LEN: begin
        blk_d[7] = count_q + 64'd1;
      end
      ghc_pkg::OP_LOAD_OUT: begin
        ws_d = cv_q;
      end
      ghc_pkg::OP_RESTART: begin
        cv_d    = '0;
        cv_d[7] = ghc_pkg::CV_INIT_LAST;
        fill_d  = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q    <= '0;
      cv_q[7] <= ghc_pkg::CV_INIT_LAST;
      fill_q  <= '0;
      count_q <= '0;
    end else begin
      cv_q    <= cv_d;
      fill_q  <= fill_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q  <= blk_d;
    ws_q   <= ws_d;
    pout_q <= pout_d;
  end

  assign status_o.full  = (fill_q >= ghc_pkg::BLOCK_BYTES);
  assign status_o.extra = (fill_q >= ghc_pkg::PAD_LIMIT);

  assign out_sel       = {1'b1, word_index_i};
  assign digest_word_o = ws_q[out_sel] ^ cv_q[out_sel];

endmodule

[src/ghc_ctrl.sv]
// Controller of the hash core: sequences absorption, padding, compression and output.
module ghc_ctrl #(
  parameter int ROUND_COUNT = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             last_item_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       word_index_o,
  output logic             last_word_o,
  input  ghc_pkg::status_t status_i,
  output ghc_pkg::cmd_t    cmd_o
);

  localparam int RndW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [RndW-1:0] RndLast = RndW'(ROUND_COUNT - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_INIT_P, S_RUN_P, S_INIT_Q, S_RUN_Q, S_FOLD,
    S_PAD, S_CLEAR, S_LEN, S_INIT_OUT, S_RUN_OUT, S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    RET_DATA, RET_EXTRA, RET_FINAL
  } ret_e;

  state_e          state_q;
  ret_e            ret_q;
  logic            last_q;
  logic [RndW-1:0] rnd_q;
  logic [1:0]      idx_q;
  logic            in_acc;
  logic            out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = (state_q == S_EMIT);
  assign word_index_o = idx_q;
  assign last_word_o  = (idx_q == 2'd3);

  always_comb begin
    cmd_o.op  = ghc_pkg::OP_NONE;
    cmd_o.rnd = 8'(rnd_q);
    case (state_q)
      S_IDLE:     cmd_o.op = in_acc ? ghc_pkg::OP_WRITE : ghc_pkg::OP_NONE;
      S_INIT_P:   cmd_o.op = ghc_pkg::OP_LOAD_P;
      S_RUN_P:    cmd_o.op = ghc_pkg::OP_ROUND_P;
      S_INIT_Q:   cmd_o.op = ghc_pkg::OP_LOAD_Q;
      S_RUN_Q:    cmd_o.op = ghc_pkg::OP_ROUND_Q;
      S_FOLD:     cmd_o.op = ghc_pkg::OP_FOLD;
      S_PAD:      cmd_o.op = ghc_pkg::OP_PAD;
      S_CLEAR:    cmd_o.op = ghc_pkg::OP_CLEAR;
      S_LEN:      cmd_o.op = ghc_pkg::OP_LEN;
      S_INIT_OUT: cmd_o.op = ghc_pkg::OP_LOAD_OUT;
      S_RUN_OUT:  cmd_o.op = ghc_pkg::OP_ROUND_P;
      S_EMIT: begin
        cmd_o.op = (out_acc && last_word_o) ? ghc_pkg::OP_RESTART : ghc_pkg::OP_NONE;
      end
      default:    cmd_o.op = ghc_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= RET_DATA;
      last_q  <= 1'b0;
      rnd_q   <= '0;
      idx_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            last_q  <= last_item_i;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (status_i.full) begin
            ret_q   <= RET_DATA;
            state_q <= S_INIT_P;
          end else if (last_q) begin
            state_q <= S_PAD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_INIT_P: begin
          rnd_q   <= '0;
          state_q <= S_RUN_P;
        end
        S_RUN_P: begin
          rnd_q <= rnd_q + 1'b1;
          if (rnd_q == RndLast) begin
            state_q <= S_INIT_Q;
          end
        end
        S_INIT_Q: begin
          rnd_q   <= '0;
          state_q <= S_RUN_Q;
        end
        S_RUN_Q: begin
          rnd_q <= rnd_q + 1'b1;
          if (rnd_q == RndLast) begin
            state_q <= S_FOLD;
          end
        end
        S_FOLD: begin
          case (ret_q)
            RET_DATA:  state_q <= last_q ? S_PAD : S_IDLE;
            RET_EXTRA: state_q <= S_CLEAR;
            RET_FINAL: state_q <= S_INIT_OUT;
            default:   state_q <= S_IDLE;
          endcase
        end
        S_PAD: begin
          if (status_i.extra) begin
            ret_q   <= RET_EXTRA;
            state_q <= S_INIT_P;
          end else begin
            state_q <= S_LEN;
          end
        end
        S_CLEAR: begin
          state_q <= S_LEN;
        end
        S_LEN: begin
          ret_q   <= RET_FINAL;
          state_q <= S_INIT_P;
        end
        S_INIT_OUT: begin
          rnd_q   <= '0;
          state_q <= S_RUN_OUT;
        end
        S_RUN_OUT: begin
          rnd_q <= rnd_q + 1'b1;
          if (rnd_q == RndLast) begin
            idx_q   <= '0;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_acc) begin
            idx_q <= idx_q + 2'd1;
            if (last_word_o) begin
              last_q  <= 1'b0;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[src/groestl256_hash_core_unit.sv]
// Top level of the Groestl-256 hash core.
// Each message word is absorbed, then the block fill is checked. A full 64-byte
// block then occupies the round unit for loading P, ROUND_COUNT rounds of P,
// loading Q, ROUND_COUNT rounds of Q and the fold, one round of P or Q per
// cycle. The last word adds padding, one or two block compressions and the
// output transformation of ROUND_COUNT rounds of P, after which the four digest
// words are presented one per cycle while out_stall_i is low, index 0 first.
// Input requests are not taken while a message is being compressed or its digest is being delivered.
module groestl256_hash_core_unit #(
  parameter int ROUND_COUNT = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] msg_word_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic        last_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] digest_word_o,
  output logic [1:0]  word_index_o,
  output logic        last_word_o
);

  ghc_pkg::cmd_t    cmd;
  ghc_pkg::status_t status;

  ghc_ctrl #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_item_i  (last_item_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  ghc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .msg_word_i    (msg_word_i),
    .valid_bytes_i (valid_bytes_i),
    .last_item_i   (last_item_i),
    .word_index_i  (word_index_o),
    .status_o      (status),
    .digest_word_o (digest_word_o)
  );

endmodule

[src/ghc_checker.sv]
// Port-level checker of the hash core and its bind to the top level.
`include "groestl256_hash_core_unit_defines.svh"

module ghc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] word_index_o,
  input logic       last_word_o
);

  `GHC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(word_index_o))
  `GHC_ASSERT(a_last_index, clk_i, rst_ni, out_valid_o |-> (last_word_o == (word_index_o == 2'd3)))
  `GHC_ASSERT(a_no_input_on_emit, clk_i, rst_ni, (in_valid_i && !in_stall_o) |-> !out_valid_o)
  `GHC_ASSERT_NEXT(a_done_after_last, clk_i, rst_ni, out_valid_o && !out_stall_i && last_word_o, !out_valid_o)

endmodule

bind groestl256_hash_core_unit ghc_checker u_ghc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .word_index_o (word_index_o),
  .last_word_o  (last_word_o)
);

[test/tb.sv]
// Self-checking testbench of the Groestl-256 hash core with a built-in digest predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [63:0] cols_t [8];

  typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } msg_req_t;

  typedef struct {
    logic [63:0] digest;
    logic [1:0]  index;
    logic        last;
  } digest_t;

  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [2:0] Q_OFFSET [8] = '{3'd1, 3'd3, 3'd5, 3'd7, 3'd0, 3'd2, 3'd4, 3'd6};
  localparam logic [7:0] MIX [8] = '{8'd2, 8'd2, 8'd3, 8'd4, 8'd5, 8'd3, 8'd5, 8'd7};

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] msg_word_i;
  logic [3:0]  valid_bytes_i;
  logic        last_item_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] digest_word_o;
  logic [1:0]  word_index_o;
  logic        last_word_o;

  cols_t       chain_cv;
  cols_t       block_buf;
  int unsigned block_bytes;
  logic [63:0] block_total;
  digest_t     pending_digests [$];
  int          error_count;
  int          requests_sent;
  int          messages_sent;
  int          words_checked;
  bit          no_idle;
  bit          hold_req;
  int          idle_cycles;

  msg_req_t directed [23] = '{
    '{64'h0, 4'd0, 1'b1},
    '{64'hffff_ffff_ffff_ffff, 4'd8, 1'b1},
    '{64'hffff_ffff_ffff_ffff, 4'd15, 1'b1},
    '{64'h61ff_ffff_ffff_ffff, 4'd1, 1'b1},
    '{64'h0123_4567_89ab_cdef, 4'd3, 1'b0},
    '{64'hfedc_ba98_7654_3210, 4'd5, 1'b1},
    '{64'h0, 4'd8, 1'b0},
    '{64'hffff_ffff_ffff_ffff, 4'd8, 1'b0},
    '{64'h0, 4'd8, 1'b0},
    '{64'hffff_ffff_ffff_ffff, 4'd8, 1'b0},
    '{64'h0, 4'd8, 1'b0},
    '{64'hffff_ffff_ffff_ffff, 4'd8, 1'b0},
    '{64'h0, 4'd8, 1'b0},
    '{64'h8000_0000_0000_00ff, 4'd1, 1'b1},
    '{64'h1111_1111_1111_1111, 4'd8, 1'b0},
    '{64'h2222_2222_2222_2222, 4'd8, 1'b0},
    '{64'h3333_3333_3333_3333, 4'd8, 1'b0},
    '{64'h4444_4444_4444_4444, 4'd8, 1'b0},
    '{64'h5555_5555_5555_5555, 4'd8, 1'b0},
    '{64'h6666_6666_6666_6666, 4'd8, 1'b0},
    '{64'h7777_7777_7777_7777, 4'd8, 1'b0},
    '{64'h8888_8888_8888_8888, 4'd0, 1'b0},
    '{64'hdead_beef_dead_beef, 4'd0, 1'b1}
  };

  groestl256_hash_core_unit i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .msg_word_i(msg_word_i), .valid_bytes_i(valid_bytes_i), .last_item_i(last_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .digest_word_o(digest_word_o), .word_index_o(word_index_o), .last_word_o(last_word_o)
  );

  function automatic logic [7:0] field_mul(logic [7:0] c, logic [7:0] x);
    logic [7:0] acc;
    acc = 8'h00;
    while (c != 8'h00) begin
      if (c[0]) acc = acc ^ x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
      c = c >> 1;
    end
    return acc;
  endfunction

  function automatic cols_t permute_state(cols_t s, bit is_q);
    logic [7:0] a [8][8];
    logic [7:0] b [8][8];
    logic [7:0] rc;
    logic [7:0] acc;
    int         sh;
    cols_t      res;
    res = s;
    for (int r = 0; r < 10; r++) begin
      for (int i = 0; i < 8; i++)
        for (int j = 0; j < 8; j++) a[i][j] = res[j][63 - 8 * i -: 8];
      for (int j = 0; j < 8; j++) begin
        rc = 8'(j << 4) ^ 8'(r);
        if (!is_q) begin
          a[0][j] = a[0][j] ^ rc;
        end else begin
          for (int i = 0; i < 8; i++) a[i][j] = a[i][j] ^ 8'hff;
          a[7][j] = a[7][j] ^ rc;
        end
      end
      for (int i = 0; i < 8; i++) begin
        sh = is_q ? int'(Q_OFFSET[i]) : i;
        for (int j = 0; j < 8; j++) b[i][j] = ghc_pkg::SBOX[a[i][(j + sh) % 8]];
      end
      for (int j = 0; j < 8; j++)
        for (int i = 0; i < 8; i++) begin
          acc = 8'h00;
          for (int k = 0; k < 8; k++) acc = acc ^ field_mul(MIX[k], b[(i + k) % 8][j]);
          res[j][63 - 8 * i -: 8] = acc;
        end
    end
    return res;
  endfunction

  task automatic compress_into_chain();
    cols_t p_in;
    cols_t p_out;
    cols_t q_out;
    for (int i = 0; i < 8; i++) p_in[i] = chain_cv[i] ^ block_buf[i];
    p_out = permute_state(p_in, 1'b0);
    q_out = permute_state(block_buf, 1'b1);
    for (int i = 0; i < 8; i++) chain_cv[i] = chain_cv[i] ^ p_out[i] ^ q_out[i];
    block_total = block_total + 64'd1;
    block_bytes = 0;
  endtask

  task automatic restart_chain();
    for (int i = 0; i < 8; i++) chain_cv[i] = 64'h0;
    chain_cv[7] = 64'h100;
    block_bytes = 0;
    block_total = 64'h0;
  endtask

  task automatic absorb_word(logic [63:0] word, logic [3:0] nb_in, logic last);
    int unsigned nb;
    cols_t       fin;
    digest_t     d;
    nb = last ? int'(nb_in) : 8;
    if (nb > 8) nb = 8;
    if (nb == 0) word = 64'h0;
    else word = word & (~64'h0 << (64 - 8 * nb));
    block_buf[(block_bytes >> 3) & 7] = word;
    block_bytes = block_bytes + nb;
    if (block_bytes >= 64) compress_into_chain();
    if (last) begin
      for (int pos = block_bytes; pos < 64; pos++)
        block_buf[pos / 8][63 - 8 * (pos % 8) -: 8] = (pos == block_bytes) ? 8'h80 : 8'h00;
      if (block_bytes + 1 > 56) begin
        compress_into_chain();
        for (int i = 0; i < 8; i++) block_buf[i] = 64'h0;
      end
      block_buf[7] = block_total + 64'd1;
      compress_into_chain();
      fin = permute_state(chain_cv, 1'b0);
      for (int k = 0; k < 4; k++) begin
        d.digest = fin[4 + k] ^ chain_cv[4 + k];
        d.index  = 2'(k);
        d.last   = (k == 3);
        pending_digests.push_back(d);
      end
      restart_chain();
      messages_sent++;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(logic [63:0] word, logic [3:0] nb, logic last);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    msg_word_i    <= word;
    valid_bytes_i <= nb;
    last_item_i   <= last;
    do @(posedge clk_i); while (in_stall_o);
    absorb_word(word, nb, last);
    requests_sent++;
  endtask

  function automatic logic [63:0] random_word();
    case ($urandom_range(0, 9))
      0: return 64'h0;
      1: return ~64'h0;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (no_idle) begin
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(10, 40)) @(negedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  initial begin
    digest_t exp_d;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_digests.size() == 0) begin
          $error("digest word without a pending expectation");
          error_count++;
        end else begin
          exp_d = pending_digests.pop_front();
          words_checked++;
          if (digest_word_o !== exp_d.digest) begin
            $error("digest_word expected %h actual %h", exp_d.digest, digest_word_o);
            error_count++;
          end
          if (word_index_o !== exp_d.index) begin
            $error("word_index expected %0d actual %0d", exp_d.index, word_index_o);
            error_count++;
          end
          if (last_word_o !== exp_d.last) begin
            $error("last_word expected %0d actual %0d", exp_d.last, last_word_o);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int n_words;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    msg_word_i    = 64'h0;
    valid_bytes_i = 4'h0;
    last_item_i   = 1'b0;
    error_count   = 0;
    requests_sent = 0;
    messages_sent = 0;
    words_checked = 0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    restart_chain();
    for (int i = 0; i < 8; i++) block_buf[i] = 64'h0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) send_request(directed[i].word, directed[i].nbytes, directed[i].last);

    while (requests_sent < 460) begin
      no_idle = ($urandom_range(0, 5) == 0);
      if (messages_sent == 20) hold_req = 1'b1;
      n_words = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 9);
      for (int w = 0; w < n_words; w++)
        send_request(random_word(), 4'($urandom_range(0, 15)), 1'b0);
      send_request(random_word(), ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15))
                                                              : 4'($urandom_range(0, 8)), 1'b1);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    wait (pending_digests.size() == 0);
    repeat (60) @(posedge clk_i);
    $display("Sent %0d message words forming %0d messages, with stalls and idle gaps.",
             requests_sent, messages_sent);
    $display("Compared %0d digest words against the predicted Groestl-256 digests.",
             words_checked);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

[files.f]
+incdir+src
src/ghc_pkg.sv
src/ghc_datapath.sv
src/ghc_ctrl.sv
src/groestl256_hash_core_unit.sv
src/ghc_checker.sv
test/tb.sv
